@@ sv/kfs_pkg.sv @@
// Shared types, codes and arithmetic helpers of the keyframe sampler.
`default_nettype none
package kfs_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int DEF_MAX_KEYS  = 64;
    localparam int WORDS_PER_KEY = 9;
    localparam int ADDR_CALC_W   = 16;
    localparam int SAT_W         = 66;
    localparam int H_W           = 20;
    localparam int ACC_W         = 56;

    localparam logic [1:0] CMD_WR_TIME = 2'd0;
    localparam logic [1:0] CMD_WR_WORD = 2'd1;
    localparam logic [1:0] CMD_SAMPLE  = 2'd2;

    localparam logic [1:0] MODE_STEP   = 2'd0;
    localparam logic [1:0] MODE_CUBIC  = 2'd2;

    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_COUNT = 2'd1;
    localparam logic [1:0] CFG_CLIP  = 2'd2;

    localparam logic [3:0] SLOT_IN  = 4'd0;
    localparam logic [3:0] SLOT_VAL = 4'd3;
    localparam logic [3:0] SLOT_OUT = 4'd6;

    typedef enum logic [4:0] {
        S_IDLE, S_T0, S_TN, S_SRCH, S_CMP, S_DIV,
        S_STEP_RD, S_STEP_CAP,
        S_LIN_RD0, S_LIN_RD1, S_LIN_MUL, S_LIN_SUM,
        S_CUB_T2, S_CUB_T3, S_CUB_H,
        S_CB_RD, S_CB_A, S_CB_B, S_CB_C, S_CB_D, S_CB_E, S_CB_F, S_CB_G, S_CB_H
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_WR_TIME, OP_WR_WORD, OP_LOAD, OP_T0, OP_TN,
        OP_SRCH_RD, OP_SRCH_CMP, OP_DIV_SETUP, OP_DIV_STEP,
        OP_STEP_RD, OP_STEP_CAP,
        OP_LIN_RD0, OP_LIN_RD1, OP_LIN_MUL, OP_LIN_SUM,
        OP_CUB_T2, OP_CUB_T3, OP_CUB_H,
        OP_CB_RD, OP_CB_A, OP_CB_B, OP_CB_C, OP_CB_D, OP_CB_E, OP_CB_F, OP_CB_G, OP_CB_H
    } t_op;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic search_more;
        logic lo_eq_hi;
        logic div_done;
        logic last_comp;
        logic mode_step;
        logic mode_cubic;
    } t_status;

    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] x);
        logic signed [SAT_W-1:0] max_v;
        logic signed [SAT_W-1:0] min_v;
        max_v = SAT_W'(64'sh0000_0000_7FFF_FFFF);
        min_v = SAT_W'(-64'sh0000_0000_8000_0000);
        if (x > max_v) begin
            return 32'sh7FFF_FFFF;
        end else if (x < min_v) begin
            return -32'sh8000_0000;
        end
        return x[31:0];
    endfunction

endpackage
`default_nettype wire

@@ sv/kfs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module kfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ sv/kfs_ctrl.sv @@
// Sequencer of the sampler: search, divide and per-component evaluation steps.
`default_nettype none
module kfs_ctrl import kfs_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic [1:0] i_cmd,
    input  wire t_status    i_status,
    output t_dp_cmd         o_cmd,
    output logic            o_busy
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_cmd)
                        CMD_WR_TIME: o_cmd.op = OP_WR_TIME;
                        CMD_WR_WORD: o_cmd.op = OP_WR_WORD;
                        CMD_SAMPLE: begin
                            o_cmd.op = OP_LOAD;
                            n_state  = S_T0;
                        end
                        default: o_cmd.op = OP_NONE;
                    endcase
                end
            end
            S_T0: begin
                o_cmd.op = OP_T0;
                n_state  = S_TN;
            end
            S_TN: begin
                o_cmd.op = OP_TN;
                n_state  = S_SRCH;
            end
            S_SRCH: begin
                if (i_status.search_more) begin
                    o_cmd.op = OP_SRCH_RD;
                    n_state  = S_CMP;
                end else begin
                    o_cmd.op = OP_DIV_SETUP;
                    n_state  = S_DIV;
                end
            end
            S_CMP: begin
                o_cmd.op = OP_SRCH_CMP;
                n_state  = S_SRCH;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV_STEP;
                if (i_status.div_done) begin
                    if (i_status.mode_step || i_status.lo_eq_hi) begin
                        n_state = S_STEP_RD;
                    end else if (i_status.mode_cubic) begin
                        n_state = S_CUB_T2;
                    end else begin
                        n_state = S_LIN_RD0;
                    end
                end
            end
            S_STEP_RD: begin
                o_cmd.op = OP_STEP_RD;
                n_state  = S_STEP_CAP;
            end
            S_STEP_CAP: begin
                o_cmd.op = OP_STEP_CAP;
                n_state  = i_status.last_comp ? S_IDLE : S_STEP_RD;
            end
            S_LIN_RD0: begin
                o_cmd.op = OP_LIN_RD0;
                n_state  = S_LIN_RD1;
            end
            S_LIN_RD1: begin
                o_cmd.op = OP_LIN_RD1;
                n_state  = S_LIN_MUL;
            end
            S_LIN_MUL: begin
                o_cmd.op = OP_LIN_MUL;
                n_state  = S_LIN_SUM;
            end
            S_LIN_SUM: begin
                o_cmd.op = OP_LIN_SUM;
                n_state  = i_status.last_comp ? S_IDLE : S_LIN_RD0;
            end
            S_CUB_T2: begin
                o_cmd.op = OP_CUB_T2;
                n_state  = S_CUB_T3;
            end
            S_CUB_T3: begin
                o_cmd.op = OP_CUB_T3;
                n_state  = S_CUB_H;
            end
            S_CUB_H: begin
                o_cmd.op = OP_CUB_H;
                n_state  = S_CB_RD;
            end
            S_CB_RD: begin
                o_cmd.op = OP_CB_RD;
                n_state  = S_CB_A;
            end
            S_CB_A: begin
                o_cmd.op = OP_CB_A;
                n_state  = S_CB_B;
            end
            S_CB_B: begin
                o_cmd.op = OP_CB_B;
                n_state  = S_CB_C;
            end
            S_CB_C: begin
                o_cmd.op = OP_CB_C;
                n_state  = S_CB_D;
            end
            S_CB_D: begin
                o_cmd.op = OP_CB_D;
                n_state  = S_CB_E;
            end
            S_CB_E: begin
                o_cmd.op = OP_CB_E;
                n_state  = S_CB_F;
            end
            S_CB_F: begin
                o_cmd.op = OP_CB_F;
                n_state  = S_CB_G;
            end
            S_CB_G: begin
                o_cmd.op = OP_CB_G;
                n_state  = S_CB_H;
            end
            S_CB_H: begin
                o_cmd.op = OP_CB_H;
                n_state  = i_status.last_comp ? S_IDLE : S_CB_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
endmodule
`default_nettype wire

@@ sv/kfs_dp.sv @@
// Datapath: config registers, key tables, search, divider and shared multiplier.
`default_nettype none
module kfs_dp import kfs_pkg::*; #(
    parameter int MAX_KEYS = DEF_MAX_KEYS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    output t_status                 o_status,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [30:0]        i_cfg_data,
    input  wire logic [5:0]         i_key_slot,
    input  wire logic [3:0]         i_word_slot,
    input  wire logic [30:0]        i_key_time,
    input  wire logic signed [31:0] i_key_word,
    input  wire logic signed [31:0] i_sample_time,
    output logic                    o_result_valid,
    output logic signed [31:0]      o_out_x,
    output logic signed [31:0]      o_out_y,
    output logic signed [31:0]      o_out_z
);
    localparam int KW  = $clog2(MAX_KEYS);
    localparam int WD  = MAX_KEYS * WORDS_PER_KEY;
    localparam int WAW = $clog2(WD);
    localparam int FW  = FRAC_BITS;
    localparam int CW  = $clog2(FRAC_BITS);
    localparam logic [ADDR_CALC_W-1:0] MAXK = ADDR_CALC_W'(MAX_KEYS);
    localparam logic [ADDR_CALC_W-1:0] WPK  = ADDR_CALC_W'(WORDS_PER_KEY);
    localparam logic signed [H_W-1:0]  H_ONE = H_W'(1) << FRAC_BITS;

    // configuration
    logic [1:0]  r_mode;
    logic [6:0]  r_count;
    logic [30:0] r_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 2'd1;
            r_count <= 7'd1;
            r_clip  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:  r_mode  <= i_cfg_data[1:0];
                CFG_COUNT: r_count <= i_cfg_data[6:0];
                CFG_CLIP:  r_clip  <= i_cfg_data;
                default:   r_mode  <= r_mode;
            endcase
        end
    end

    logic [ADDR_CALC_W-1:0] w_cnt16, w_n16, w_nm116;
    logic [KW-1:0]          w_nm1;
    assign w_cnt16 = ADDR_CALC_W'(r_count);
    assign w_n16   = (w_cnt16 == '0) ? ADDR_CALC_W'(1) : ((w_cnt16 > MAXK) ? MAXK : w_cnt16);
    assign w_nm116 = w_n16 - ADDR_CALC_W'(1);
    assign w_nm1   = w_nm116[KW-1:0];

    // sample state
    logic [30:0]            r_t, r_tlo, r_thi, r_dt;
    logic [KW-1:0]          r_lo, r_hi, r_mid;
    logic [31:0]            r_rem;
    logic [FW-1:0]          r_q, r_t2;
    logic                   r_fz;
    logic [CW-1:0]          r_cnt;
    logic signed [H_W-1:0]  r_h00, r_h10, r_h01, r_h11;
    logic signed [31:0]     r_m, r_w;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [64:0]     r_prod;
    logic [1:0]             r_ci;
    logic                   r_valid;
    logic signed [31:0]     r_out_x, r_out_y, r_out_z;

    // tables
    logic [ADDR_CALC_W-1:0] w_ks16, w_wa16, w_ra16, w_rkey16;
    logic [KW-1:0]          w_rkey, w_traddr;
    logic [3:0]             w_rslot;
    logic                   w_twe, w_wwe;
    logic [30:0]            w_trd;
    logic [31:0]            w_wrd_u;
    logic signed [31:0]     w_wrd;

    assign w_ks16 = ADDR_CALC_W'(i_key_slot);
    assign w_wa16 = (w_ks16 << 3) + w_ks16 + ADDR_CALC_W'(i_word_slot);
    assign w_twe  = (i_cmd.op == OP_WR_TIME) && (w_ks16 < MAXK);
    assign w_wwe  = (i_cmd.op == OP_WR_WORD) && (w_ks16 < MAXK)
                    && (ADDR_CALC_W'(i_word_slot) < WPK);

    logic [KW:0] w_mid_sum;
    logic [KW-1:0] w_mid;
    assign w_mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid     = w_mid_sum[KW:1];

    always_comb begin
        case (i_cmd.op)
            OP_LOAD:    w_traddr = '0;
            OP_T0:      w_traddr = w_nm1;
            OP_SRCH_RD: w_traddr = w_mid;
            default:    w_traddr = r_mid;
        endcase
    end

    always_comb begin
        w_rkey  = r_lo;
        w_rslot = SLOT_VAL + {2'b00, r_ci};
        case (i_cmd.op)
            OP_LIN_RD1: w_rkey = r_hi;
            OP_CB_RD:   w_rslot = SLOT_OUT + {2'b00, r_ci};
            OP_CB_B:    w_rkey = r_hi;
            OP_CB_C: begin
                w_rkey  = r_hi;
                w_rslot = SLOT_IN + {2'b00, r_ci};
            end
            default:    w_rkey = r_lo;
        endcase
    end

    assign w_rkey16 = ADDR_CALC_W'(w_rkey);
    assign w_ra16   = (w_rkey16 << 3) + w_rkey16 + ADDR_CALC_W'(w_rslot);

    kfs_ram #(.WIDTH(31), .DEPTH(MAX_KEYS)) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (w_twe),
        .i_waddr (w_ks16[KW-1:0]),
        .i_wdata (i_key_time),
        .i_raddr (w_traddr),
        .o_rdata (w_trd)
    );

    kfs_ram #(.WIDTH(32), .DEPTH(WD)) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (w_wwe),
        .i_waddr (w_wa16[WAW-1:0]),
        .i_wdata (i_key_word),
        .i_raddr (w_ra16[WAW-1:0]),
        .o_rdata (w_wrd_u)
    );
    assign w_wrd = w_wrd_u;

    // clamp of the query time
    logic [30:0] w_tclamp;
    always_comb begin
        if (i_sample_time[31]) begin
            w_tclamp = '0;
        end else if ($signed({1'b0, r_clip}) < i_sample_time) begin
            w_tclamp = r_clip;
        end else begin
            w_tclamp = i_sample_time[30:0];
        end
    end

    // divider and fraction
    logic [31:0]   w_dt_s;
    logic          w_dt_pos;
    logic [32:0]   w_sh;
    logic [FW-1:0] w_f;
    assign w_dt_s   = {1'b0, r_thi} - {1'b0, r_tlo};
    assign w_dt_pos = !w_dt_s[31] && (w_dt_s != '0) && (r_t >= r_tlo);
    assign w_sh     = {r_rem, 1'b0};
    assign w_f      = r_fz ? '0 : r_q;

    // Hermite basis
    logic [FW-1:0]         w_t3;
    logic signed [H_W-1:0] w_t2s, w_t3s, w_fs;
    assign w_t3  = r_prod[2*FW-1:FW];
    assign w_t2s = H_W'(r_t2);
    assign w_t3s = H_W'(w_t3);
    assign w_fs  = H_W'(w_f);

    // shared multiplier, registered product
    logic signed [32:0] w_mul_a;
    logic signed [31:0] w_mul_b;
    logic signed [64:0] w_prod;
    logic               w_mul_en;
    assign w_prod = w_mul_a * w_mul_b;

    logic signed [ACC_W-1:0] w_accsum;
    logic signed [31:0]      w_msat;
    assign w_accsum = r_acc + ACC_W'(r_prod);
    assign w_msat   = sat32(SAT_W'(r_prod >>> FRAC_BITS));

    logic               w_res_en;
    logic signed [31:0] w_res;

    always_comb begin
        w_mul_a  = '0;
        w_mul_b  = '0;
        w_mul_en = 1'b0;
        w_res_en = 1'b0;
        w_res    = w_wrd;
        case (i_cmd.op)
            OP_STEP_CAP: w_res_en = 1'b1;
            OP_LIN_MUL: begin
                w_mul_a  = 33'(w_wrd) - 33'(r_w);
                w_mul_b  = 32'(w_f);
                w_mul_en = 1'b1;
            end
            OP_LIN_SUM: begin
                w_res    = sat32(SAT_W'(r_w) + SAT_W'(r_prod >>> FRAC_BITS));
                w_res_en = 1'b1;
            end
            OP_CUB_T2: begin
                w_mul_a  = 33'(w_f);
                w_mul_b  = 32'(w_f);
                w_mul_en = 1'b1;
            end
            OP_CUB_T3: begin
                w_mul_a  = 33'(r_prod[2*FW-1:FW]);
                w_mul_b  = 32'(w_f);
                w_mul_en = 1'b1;
            end
            OP_CB_A: begin
                w_mul_a  = 33'(w_wrd);
                w_mul_b  = 32'(r_dt);
                w_mul_en = 1'b1;
            end
            OP_CB_B: begin
                w_mul_a  = 33'(r_h00);
                w_mul_b  = w_wrd;
                w_mul_en = 1'b1;
            end
            OP_CB_C: begin
                w_mul_a  = 33'(r_h10);
                w_mul_b  = r_m;
                w_mul_en = 1'b1;
            end
            OP_CB_D: begin
                w_mul_a  = 33'(r_h01);
                w_mul_b  = r_w;
                w_mul_en = 1'b1;
            end
            OP_CB_E: begin
                w_mul_a  = 33'(r_w);
                w_mul_b  = 32'(r_dt);
                w_mul_en = 1'b1;
            end
            OP_CB_G: begin
                w_mul_a  = 33'(r_h11);
                w_mul_b  = r_m;
                w_mul_en = 1'b1;
            end
            OP_CB_H: begin
                w_res    = sat32(SAT_W'(w_accsum >>> FRAC_BITS));
                w_res_en = 1'b1;
            end
            default: w_mul_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mul_en) begin
            r_prod <= w_prod;
        end
        case (i_cmd.op)
            OP_LOAD: r_t <= w_tclamp;
            OP_T0:   r_tlo <= w_trd;
            OP_TN: begin
                r_thi <= w_trd;
                if ((w_nm1 == '0) || (r_t <= r_tlo)) begin
                    r_lo <= '0;
                    r_hi <= '0;
                end else if (r_t >= w_trd) begin
                    r_lo <= w_nm1;
                    r_hi <= w_nm1;
                end else begin
                    r_lo <= '0;
                    r_hi <= w_nm1;
                end
            end
            OP_SRCH_RD: r_mid <= w_mid;
            OP_SRCH_CMP: begin
                if (w_trd <= r_t) begin
                    r_lo  <= r_mid;
                    r_tlo <= w_trd;
                end else begin
                    r_hi  <= r_mid;
                    r_thi <= w_trd;
                end
            end
            OP_DIV_SETUP: begin
                r_rem <= 32'(r_t - r_tlo);
                r_dt  <= w_dt_pos ? w_dt_s[30:0] : '0;
                r_fz  <= !w_dt_pos;
                r_q   <= '0;
            end
            OP_DIV_STEP: begin
                if (w_sh >= {2'b00, r_dt}) begin
                    r_rem <= 32'(w_sh - {2'b00, r_dt});
                    r_q   <= {r_q[FW-2:0], 1'b1};
                end else begin
                    r_rem <= w_sh[31:0];
                    r_q   <= {r_q[FW-2:0], 1'b0};
                end
            end
            OP_LIN_RD1: r_w <= w_wrd;
            OP_CUB_T3:  r_t2 <= r_prod[2*FW-1:FW];
            OP_CUB_H: begin
                r_h00 <= (w_t3s <<< 1) - (w_t2s <<< 1) - w_t2s + H_ONE;
                r_h10 <= w_t3s - (w_t2s <<< 1) + w_fs;
                r_h01 <= (w_t2s <<< 1) + w_t2s - (w_t3s <<< 1);
                r_h11 <= w_t3s - w_t2s;
            end
            OP_CB_B: r_m <= w_msat;
            OP_CB_C: begin
                r_acc <= ACC_W'(r_prod);
                r_w   <= w_wrd;
            end
            OP_CB_D: begin
                r_acc <= w_accsum;
                r_w   <= w_wrd;
            end
            OP_CB_E: r_acc <= w_accsum;
            OP_CB_F: r_m <= w_msat;
            default: r_m <= r_m;
        endcase
        if (w_res_en) begin
            case (r_ci)
                2'd0:    r_out_x <= w_res;
                2'd1:    r_out_y <= w_res;
                default: r_out_z <= w_res;
            endcase
        end
    end

    // control state of the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ci    <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_res_en && (r_ci == 2'd2);
            if (i_cmd.op == OP_LOAD) begin
                r_ci <= '0;
            end else if (w_res_en) begin
                r_ci <= r_ci + 2'd1;
            end
            if (i_cmd.op == OP_DIV_SETUP) begin
                r_cnt <= '0;
            end else if (i_cmd.op == OP_DIV_STEP) begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    logic [ADDR_CALC_W-1:0] w_span;
    assign w_span = ADDR_CALC_W'(r_hi) - ADDR_CALC_W'(r_lo);

    assign o_status.search_more = (w_span > ADDR_CALC_W'(1));
    assign o_status.lo_eq_hi    = (r_lo == r_hi);
    assign o_status.div_done    = (r_cnt == CW'(FRAC_BITS - 1));
    assign o_status.last_comp   = (r_ci == 2'd2);
    assign o_status.mode_step   = (r_mode == MODE_STEP);
    assign o_status.mode_cubic  = (r_mode == MODE_CUBIC);

    assign o_result_valid = r_valid;
    assign o_out_x        = r_out_x;
    assign o_out_y        = r_out_y;
    assign o_out_z        = r_out_z;
endmodule
`default_nettype wire

@@ sv/keyframe_vec3_sampler.sv @@
// Top level of the xyz keyframe sampler: sequencer plus datapath.
//
//  channel   | ports                                          | accepted when
//  ----------+------------------------------------------------+------------------------
//  command   | i_cmd i_key_slot i_word_slot i_key_time        | start && !busy
//            | i_key_word i_sample_time                       |
//  result    | o_out_x o_out_y o_out_z                        | o_result_valid (1 cycle)
//  config    | i_cfg_idx i_cfg_data                           | i_cfg_we
//
// Write commands give no result. A sample beat runs the first and last
// key-time reads, the binary search with a read and a compare per step (up
// to 6 steps at 64 keys), divider setup, the divider for 16 quotient bits,
// then the step, linear or cubic evaluation (cubic: the basis first, then
// each component) on one shared multiplier and one word-table read port.
// busy is high from acceptance until the result strobe. Reset is synchronous,
// active low, and clears config and control only; table contents stay
// undefined until written. Results cannot be held off by the receiver.
`default_nettype none
module keyframe_vec3_sampler import kfs_pkg::*; #(
    parameter int MAX_KEYS = DEF_MAX_KEYS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         i_cmd,
    input  wire logic [5:0]         i_key_slot,
    input  wire logic [3:0]         i_word_slot,
    input  wire logic [30:0]        i_key_time,
    input  wire logic signed [31:0] i_key_word,
    input  wire logic signed [31:0] i_sample_time,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [30:0]        i_cfg_data,
    output logic                    o_result_valid,
    output logic signed [31:0]      o_out_x,
    output logic signed [31:0]      o_out_y,
    output logic signed [31:0]      o_out_z
);
    t_dp_cmd w_cmd;
    t_status w_status;

    kfs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_cmd    (i_cmd),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    kfs_dp #(.MAX_KEYS(MAX_KEYS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_key_slot     (i_key_slot),
        .i_word_slot    (i_word_slot),
        .i_key_time     (i_key_time),
        .i_key_word     (i_key_word),
        .i_sample_time  (i_sample_time),
        .o_result_valid (o_result_valid),
        .o_out_x        (o_out_x),
        .o_out_y        (o_out_y),
        .o_out_z        (o_out_z)
    );
endmodule
`default_nettype wire
